FILE: hdl/pwsa_pkg.sv
// Shared types and constants for the pairwise SASA accumulator.
// No dependencies; imported by the front, queue, back and top-level modules.
package pwsa_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int PAIR_SHIFT = 2 * FRAC_BITS - 30;
  localparam int AREA_SHIFT = FRAC_BITS + 24;
  localparam logic [27:0] FOURPI_Q24 = 28'd210828714;
  localparam logic signed [35:0] ONE_Q30 = 36'sd1073741824;
  localparam logic [33:0] TERM_CAP = 34'h200000000;
  localparam int SQRT_STEPS = 26;
  localparam int NUM_W = 81;
  localparam int DEN_W = 47;

  typedef enum logic [1:0] {
    REG_PROBE  = 2'd0,
    REG_BONDED = 2'd1,
    REG_OTHER  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [19:0] probe_radius;
    logic [16:0] bonded_pair_factor;
    logic [16:0] other_pair_factor;
  } cfg_t;

  typedef struct packed {
    logic [19:0]        atom_radius;
    logic [18:0]        atom_p;
    logic signed [21:0] atom_sigma;
    logic               atom_skipped;
    logic [19:0]        neighbor_radius;
    logic               neighbor_skipped;
    logic               pair_bonded;
    logic signed [25:0] delta_x;
    logic signed [25:0] delta_y;
    logic signed [25:0] delta_z;
    logic               last_neighbor;
    logic               clear_totals;
  } item_t;

  typedef struct packed {
    logic [19:0]        ri;
    logic [18:0]        p;
    logic signed [21:0] sigma;
    logic               askip;
    logic [19:0]        rj;
    logic               contrib;
    logic               bonded;
    logic [50:0]        sqx;
    logic [50:0]        sqy;
    logic [50:0]        sqz;
    logic               last;
    logic               clr;
  } pair_t;

  typedef struct packed {
    logic signed [29:0] atom_area;
    logic [39:0]        total_area;
    logic signed [47:0] total_energy;
    logic               saturated;
  } res_t;

endpackage

FILE: hdl/pwsa_front.sv
// Front end: takes pair words, classifies them and squares the coordinate deltas.
// Depends on pwsa_pkg.
module pwsa_front import pwsa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  q_valid,
  input  logic  q_ready,
  output pair_t q_item
);

  logic  a_valid, b_valid, advance;
  item_t a_item;
  pair_t b_ent;
  logic [25:0] ax, ay, az;

  assign advance  = !b_valid || q_ready;
  assign in_ready = !a_valid || advance;
  assign q_valid  = b_valid;
  assign q_item   = b_ent;

  always_comb begin
    ax = a_item.delta_x[25] ? 26'(-a_item.delta_x) : 26'(a_item.delta_x);
    ay = a_item.delta_y[25] ? 26'(-a_item.delta_y) : 26'(a_item.delta_y);
    az = a_item.delta_z[25] ? 26'(-a_item.delta_z) : 26'(a_item.delta_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (advance) b_valid <= a_valid;
      if (in_ready) a_valid <= in_valid;
    end
    if (in_ready && in_valid) a_item <= in_item;
    if (advance && a_valid) begin
      b_ent.ri      <= a_item.atom_radius;
      b_ent.p       <= a_item.atom_p;
      b_ent.sigma   <= a_item.atom_sigma;
      b_ent.askip   <= a_item.atom_skipped;
      b_ent.rj      <= a_item.neighbor_radius;
      b_ent.contrib <= !a_item.atom_skipped && !a_item.neighbor_skipped;
      b_ent.bonded  <= a_item.pair_bonded;
      b_ent.sqx     <= 51'(ax * ax);
      b_ent.sqy     <= 51'(ay * ay);
      b_ent.sqz     <= 51'(az * az);
      b_ent.last    <= a_item.last_neighbor;
      b_ent.clr     <= a_item.clear_totals;
    end
  end

endmodule

FILE: hdl/pwsa_queue.sv
// Short FIFO of classified pair words between front and back end.
// Depends on pwsa_pkg.
module pwsa_queue import pwsa_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  pair_t wr_data,
  output logic  rd_valid,
  input  logic  rd_ready,
  output pair_t rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pair_t         mem [DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;
  logic          push, pop;

  assign wr_ready = count != CW'(DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = mem[rptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop) rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
    if (push) mem[wptr] <= wr_data;
  end

endmodule

FILE: hdl/pwsa_back.sv
// Back end: distance, overlap term, running product, atom area and totals.
// Depends on pwsa_pkg.
module pwsa_back import pwsa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  q_valid,
  output logic  q_ready,
  input  pair_t q_item,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  typedef enum logic [14:0] {
    ST_IDLE  = 15'h0001,
    ST_SQRT  = 15'h0002,
    ST_GEOM  = 15'h0004,
    ST_MULA  = 15'h0008,
    ST_MULB  = 15'h0010,
    ST_MULC  = 15'h0020,
    ST_DIV   = 15'h0040,
    ST_FACT  = 15'h0080,
    ST_PROD  = 15'h0100,
    ST_AREA1 = 15'h0200,
    ST_AREA2 = 15'h0400,
    ST_AREA3 = 15'h0800,
    ST_AREA4 = 15'h1000,
    ST_TOT   = 15'h2000,
    ST_ENG   = 15'h4000
  } state_t;

  state_t state;
  pair_t  cur;
  logic   in_atom, sat;
  logic signed [31:0] prod, factor;
  logic [39:0] area_total;
  logic signed [47:0] energy_total;
  logic [51:0] sq_v, sq_res;
  logic [4:0]  cnt;
  logic [6:0]  div_cnt;
  logic [21:0] dd;
  logic [22:0] as_mag;
  logic        neg;
  logic [35:0] pp;
  logic [44:0] nabs;
  logic [DEN_W-1:0] den4;
  logic [NUM_W-1:0] num;
  logic [47:0] rem;
  logic [33:0] quo;
  logic        ovf;
  logic [41:0] rip2;
  logic [48:0] sa_lo;
  logic [29:0] sarea;
  logic signed [29:0] area;
  logic signed [51:0] esum;

  logic [20:0] rip;
  logic [21:0] cut;
  logic [25:0] rij;
  logic signed [27:0] s_val;
  logic [16:0] pij;
  logic [35:0] pp_c;
  logic [51:0] bitv, trial;
  logic [47:0] r2;
  logic        ge;
  logic [33:0] term;
  logic        term_sat;
  logic signed [35:0] fwide;
  logic signed [63:0] pwide, pshift;
  logic [69:0] sa_full;
  logic [31:0] pm;
  logic [61:0] mwide;
  logic signed [32:0] aval;
  logic signed [41:0] at_sum;
  logic signed [51:0] eshift;
  logic signed [48:0] e_sum;
  logic signed [47:0] e_new;
  logic        e_sat;
  state_t      after_pair;

  assign q_ready = state == ST_IDLE;

  always_comb begin
    rip   = 21'(cur.ri) + 21'(cfg.probe_radius);
    cut   = 22'(cur.ri) + 22'(cur.rj) + {1'b0, cfg.probe_radius, 1'b0};
    rij   = sq_res[25:0];
    s_val = 28'(rij) + 28'(cur.rj) - 28'(cur.ri);
    pij   = cur.bonded ? cfg.bonded_pair_factor : cfg.other_pair_factor;
    pp_c  = 36'(cur.p * pij);
    bitv  = 52'(1) << {cnt, 1'b0};
    trial = sq_res + bitv;
    r2    = {rem[46:0], num[NUM_W-1]};
    ge    = r2 >= 48'(den4);
    term_sat = ovf || (quo > TERM_CAP);
    term  = term_sat ? TERM_CAP : quo;
    fwide = neg ? (ONE_Q30 + $signed(36'(term))) : (ONE_Q30 - $signed(36'(term)));
    pwide = prod * factor;
    pshift = pwide >>> 30;
    sa_full = 70'(sa_lo) + (70'(rip2[41:21] * FOURPI_Q24) << 21);
    pm    = prod[31] ? 32'(-prod) : 32'(prod);
    mwide = 62'(sarea * pm);
    aval  = prod[31] ? -$signed({1'b0, mwide[61:30]}) : $signed({1'b0, mwide[61:30]});
    at_sum = $signed({2'b00, area_total}) + 42'(area);
    eshift = esum >>> FRAC_BITS;
    e_sum = 49'(energy_total) + eshift[48:0];
    e_sat = 1'b0;
    if (e_sum > 49'sd140737488355327) begin
      e_new = 48'sh7FFFFFFFFFFF;
      e_sat = 1'b1;
    end else if (e_sum < -49'sd140737488355328) begin
      e_new = 48'sh800000000000;
      e_sat = 1'b1;
    end else begin
      e_new = e_sum[47:0];
    end
    after_pair = cur.last ? ST_AREA1 : ST_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      in_atom      <= 1'b0;
      sat          <= 1'b0;
      prod         <= 32'sh40000000;
      area_total   <= '0;
      energy_total <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_ENG) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur    <= q_item;
            sq_v   <= 52'(q_item.sqx) + 52'(q_item.sqy) + 52'(q_item.sqz);
            sq_res <= '0;
            cnt    <= 5'(SQRT_STEPS - 1);
            if (!in_atom) begin
              if (q_item.clr) begin
                area_total   <= '0;
                energy_total <= '0;
              end
              prod    <= 32'sh40000000;
              sat     <= 1'b0;
              in_atom <= 1'b1;
            end
            if (q_item.contrib) state <= ST_SQRT;
            else if (q_item.last) state <= ST_AREA1;
          end
        end
        ST_SQRT: begin
          if (sq_v >= trial) begin
            sq_v   <= sq_v - trial;
            sq_res <= (sq_res >> 1) + bitv;
          end else begin
            sq_res <= sq_res >> 1;
          end
          if (cnt == '0) state <= ST_GEOM;
          else cnt <= cnt - 1'b1;
        end
        ST_GEOM: begin
          dd     <= cut - rij[21:0];
          neg    <= s_val[27];
          as_mag <= s_val[27] ? 23'(-s_val) : 23'(s_val);
          pp     <= pp_c;
          if (rip == '0 || rij == '0 || rij > 26'(cut) || 26'(cut) == rij ||
              s_val == '0 || pp_c == '0) begin
            state <= after_pair;
          end else begin
            state <= ST_MULA;
          end
        end
        ST_MULA: begin
          nabs  <= 45'(dd * as_mag);
          den4  <= DEN_W'(43'(rij[21:0] * rip) << (2 + PAIR_SHIFT));
          state <= ST_MULB;
        end
        ST_MULB: begin
          num   <= NUM_W'(pp * nabs[22:0]);
          state <= ST_MULC;
        end
        ST_MULC: begin
          num     <= num + (NUM_W'(pp * nabs[44:23]) << 23);
          rem     <= '0;
          quo     <= '0;
          ovf     <= 1'b0;
          div_cnt <= 7'(NUM_W - 1);
          state   <= ST_DIV;
        end
        ST_DIV: begin
          num <= num << 1;
          rem <= ge ? r2 - 48'(den4) : r2;
          quo <= {quo[32:0], ge};
          ovf <= ovf | quo[33];
          if (div_cnt == '0) state <= ST_FACT;
          else div_cnt <= div_cnt - 1'b1;
        end
        ST_FACT: begin
          if (fwide > 36'sd2147483647) begin
            factor <= 32'sh7FFFFFFF;
            sat    <= 1'b1;
          end else if (fwide < -36'sd2147483648) begin
            factor <= 32'sh80000000;
            sat    <= 1'b1;
          end else begin
            factor <= fwide[31:0];
            if (term_sat) sat <= 1'b1;
          end
          state <= ST_PROD;
        end
        ST_PROD: begin
          if (pshift > 64'sd2147483647) begin
            prod <= 32'sh7FFFFFFF;
            sat  <= 1'b1;
          end else if (pshift < -64'sd2147483648) begin
            prod <= 32'sh80000000;
            sat  <= 1'b1;
          end else begin
            prod <= pshift[31:0];
          end
          state <= after_pair;
        end
        ST_AREA1: begin
          rip2 <= 42'(rip * rip);
          if (cur.askip) begin
            area  <= '0;
            state <= ST_TOT;
          end else begin
            state <= ST_AREA2;
          end
        end
        ST_AREA2: begin
          sa_lo <= 49'(rip2[20:0] * FOURPI_Q24);
          state <= ST_AREA3;
        end
        ST_AREA3: begin
          sarea <= 30'(sa_full >> AREA_SHIFT);
          state <= ST_AREA4;
        end
        ST_AREA4: begin
          if (aval > 33'sd536870911) begin
            area <= 30'sh1FFFFFFF;
            sat  <= 1'b1;
          end else if (aval < -33'sd536870912) begin
            area <= 30'sh20000000;
            sat  <= 1'b1;
          end else begin
            area <= aval[29:0];
          end
          state <= ST_TOT;
        end
        ST_TOT: begin
          if (at_sum < 0) begin
            area_total <= '0;
            sat        <= 1'b1;
          end else if (at_sum > 42'sd1099511627775) begin
            area_total <= '1;
            sat        <= 1'b1;
          end else begin
            area_total <= at_sum[39:0];
          end
          esum  <= cur.sigma * area;
          state <= ST_ENG;
        end
        ST_ENG: begin
          if (!out_valid || out_ready) begin
            energy_total <= e_new;
            sat          <= sat | e_sat;
            out_res.atom_area    <= area;
            out_res.total_area   <= area_total;
            out_res.total_energy <= e_new;
            out_res.saturated    <= sat | e_sat;
            out_valid <= 1'b1;
            in_atom   <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/pairwise_sasa_accumulator.sv
// Top level of the pairwise SASA accumulator: config registers, front, queue, back.
// Depends on pwsa_pkg, pwsa_front, pwsa_queue, pwsa_back.
//
// Usage: one s_axis word per (atom, neighbour) pair; tlast marks the last
// pair of an atom. On that word one m_axis word carries the atom area and the
// running area and energy totals; other words give no result.
// The cfg channel (always ready) writes probe radius and pair factors; the user
// must write them only while no atom is in flight; the block does not enforce it.
// The front and queue register each pair; the back end takes a pair only when
// idle. A pair with no contribution is passed over; a contributing pair uses
// the digit-by-digit square root and, when the spheres overlap, the bit-serial
// overlap divider and the running product. The last pair of an atom then adds
// the area steps and the totals (a skipped atom gets area zero, most area steps
// skipped). The back end finishes one pair before it takes the next.
// Reset empties front and queue, clears totals and drops the output valid.
// When m_axis stalls, the finished word is held; the front and queue keep
// taking pairs until both are full, then s_axis_tready drops.
module pairwise_sasa_accumulator import pwsa_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // atom_radius, atom_p, atom_sigma, neighbor_radius, delta_x, delta_y, delta_z
  input  logic [159:0] s_axis_tdata,
  // atom_skipped, neighbor_skipped, pair_bonded, clear_totals
  input  logic [3:0]   s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // atom_area, total_area, total_energy
  output logic [119:0] m_axis_tdata,
  // saturated
  output logic [0:0]   m_axis_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [19:0]  cfg_data
);

  cfg_t  cfg;
  item_t in_item;
  pair_t fq_item, qb_item;
  logic  fq_valid, fq_ready, qb_valid, qb_ready;
  res_t  res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.probe_radius       <= 20'd91750;
      cfg.bonded_pair_factor <= 17'd58163;
      cfg.other_pair_factor  <= 17'd23042;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PROBE:  cfg.probe_radius       <= cfg_data;
        REG_BONDED: cfg.bonded_pair_factor <= cfg_data[16:0];
        REG_OTHER:  cfg.other_pair_factor  <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_item.atom_radius      = s_axis_tdata[19:0];
    in_item.atom_p           = s_axis_tdata[38:20];
    in_item.atom_sigma       = s_axis_tdata[60:39];
    in_item.atom_skipped     = s_axis_tuser[0];
    in_item.neighbor_radius  = s_axis_tdata[80:61];
    in_item.neighbor_skipped = s_axis_tuser[1];
    in_item.pair_bonded      = s_axis_tuser[2];
    in_item.delta_x          = s_axis_tdata[106:81];
    in_item.delta_y          = s_axis_tdata[132:107];
    in_item.delta_z          = s_axis_tdata[158:133];
    in_item.last_neighbor    = s_axis_tlast;
    in_item.clear_totals     = s_axis_tuser[3];
  end

  pwsa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_item  (in_item),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_item   (fq_item)
  );

  pwsa_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_item),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_item)
  );

  pwsa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_item    (qb_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  assign m_axis_tdata = {2'b00, res.total_energy, res.total_area, res.atom_area};
  assign m_axis_tuser = res.saturated;

endmodule

FILE: hdl/pwsa_checker.sv
// Port-level checks for the pairwise SASA accumulator, bound to the top level.
// Depends on pairwise_sasa_accumulator.
module pwsa_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [119:0] m_axis_tdata,
  input logic [0:0]   m_axis_tuser,
  input logic         cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  a_rst_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_rst_in: assert property (@(posedge clk) rst |=> s_axis_tready)
    else $error("input not ready after reset");

  a_cfg_rdy: assert property (@(posedge clk) disable iff (rst) !$past(rst) |-> cfg_ready)
    else $error("config channel not ready");

endmodule

bind pairwise_sasa_accumulator pwsa_checker u_pwsa_checker (.*);
